// ===== design/assert_macros.svh =====
// Assertion macros for the DC mean and offset corrector checker.
// Both macros sample on the rising edge of clk; the first is masked while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property outside reset
`define DCM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every edge, reset included
`define DCM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/dcm_pkg.sv =====
// Shared types and constants for the DC mean and offset corrector.
// No dependencies; the design files that use it refer to it by scoped names, the testbench imports it.
`timescale 1ns / 1ps
`default_nettype none

package dcm_pkg;

  localparam int SAMPLE_BITS        = 16;
  localparam int MAX_COUNT_BITS_DEF = 24;
  localparam int MEAN_BITS          = 32;
  localparam int FRAC_BITS          = 16;
  localparam int CFG_BITS           = 16;

  // Request kinds
  localparam logic REQ_MEASURE = 1'b0;
  localparam logic REQ_CORRECT = 1'b1;

  // Result kinds
  localparam logic RES_STATS  = 1'b0;
  localparam logic RES_SAMPLE = 1'b1;

  // Register indexes
  localparam logic CFG_APPLY_OFFSET  = 1'b0;
  localparam logic CFG_TARGET_OFFSET = 1'b1;

  typedef struct packed {
    logic                          req_type;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;
  } req_word_t;

  typedef struct packed {
    logic                          result_kind;
    logic signed [MEAN_BITS-1:0]   mean_signed;
    logic        [MEAN_BITS-1:0]   mean_abs;
    logic signed [SAMPLE_BITS-1:0] correction;
    logic signed [SAMPLE_BITS-1:0] corrected_sample;
    logic                          count_saturated;
  } res_word_t;

  // Width of one job word in the front-to-back queue:
  // kind, sample, signed sum, magnitude sum, count, saturation flag.
  function automatic int job_bits(int count_bits);
    return 1 + SAMPLE_BITS + 2 * (SAMPLE_BITS + count_bits) + (count_bits + 1) + 1;
  endfunction

endpackage

`default_nettype wire

// ===== design/dcm_queue.sv =====
// Two-entry job queue between the front and back parts.
// Generic on word width; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module dcm_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         not_empty
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);

  logic [W-1:0]     slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   fill;

  assign full      = (fill == (PTR_W + 1)'(DEPTH));
  assign not_empty = (fill != '0);
  assign pop_data  = slots[rd_ptr];

  // Store pushed words
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/dcm_front.sv =====
// Front part: takes request words, accumulates measure samples, queues jobs.
// Depends on dcm_pkg for the request word type and job width.
`timescale 1ns / 1ps
`default_nettype none

module dcm_front #(
  parameter int MAX_COUNT_BITS = dcm_pkg::MAX_COUNT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  dcm_pkg::req_word_t  req_word,
  output logic                req_stall,
  input  logic                q_full,
  output logic                q_push,
  output logic [dcm_pkg::job_bits(MAX_COUNT_BITS)-1:0] q_data
);

  localparam int SB    = dcm_pkg::SAMPLE_BITS;
  localparam int CNT_W = MAX_COUNT_BITS + 1;
  localparam int SUM_W = SB + MAX_COUNT_BITS;

  logic signed [SUM_W-1:0] signed_sum;
  logic        [SUM_W-1:0] magnitude_sum;
  logic        [CNT_W-1:0] sample_count;
  logic                    saturated_flag;

  logic                    take;
  logic                    is_correct;
  logic                    at_limit;
  logic        [SB-1:0]    smp_mag;
  logic signed [SUM_W-1:0] sum_upd;
  logic        [SUM_W-1:0] mag_upd;
  logic        [CNT_W-1:0] cnt_upd;
  logic                    sat_upd;

  assign req_stall  = q_full;
  assign take       = req_valid && !q_full;
  assign is_correct = (req_word.req_type == dcm_pkg::REQ_CORRECT);
  assign at_limit   = sample_count[CNT_W-1];

  // Accumulate unless the counter has hit its limit
  always_comb begin
    smp_mag = req_word.sample[SB-1] ? SB'(-req_word.sample) : SB'(req_word.sample);
    if (at_limit) begin
      sum_upd = signed_sum;
      mag_upd = magnitude_sum;
      cnt_upd = sample_count;
    end else begin
      sum_upd = signed_sum + SUM_W'(req_word.sample);
      mag_upd = magnitude_sum + SUM_W'(smp_mag);
      cnt_upd = sample_count + 1'b1;
    end
    sat_upd = saturated_flag | at_limit;
  end

  // Queue a job for every correct word and for the last measure word
  assign q_push = take && (is_correct || req_word.last);
  assign q_data = {req_word.req_type, req_word.sample, sum_upd, mag_upd, cnt_upd, sat_upd};

  // Hold the accumulators; clear them when a pass ends
  always_ff @(posedge clk) begin
    if (rst) begin
      signed_sum     <= '0;
      magnitude_sum  <= '0;
      sample_count   <= '0;
      saturated_flag <= 1'b0;
    end else if (take && !is_correct) begin
      if (req_word.last) begin
        signed_sum     <= '0;
        magnitude_sum  <= '0;
        sample_count   <= '0;
        saturated_flag <= 1'b0;
      end else begin
        signed_sum     <= sum_upd;
        magnitude_sum  <= mag_upd;
        sample_count   <= cnt_upd;
        saturated_flag <= sat_upd;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/dcm_back.sv =====
// Back part: carries out queued jobs, divides for the means and the correction,
// applies the latched correction and holds the result register. Uses dcm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dcm_back #(
  parameter int MAX_COUNT_BITS = dcm_pkg::MAX_COUNT_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  apply_offset,
  input  logic signed [dcm_pkg::CFG_BITS-1:0]   target_offset,
  input  logic                                  q_not_empty,
  input  logic [dcm_pkg::job_bits(MAX_COUNT_BITS)-1:0] q_data,
  output logic                                  q_pop,
  output logic                                  res_valid,
  input  logic                                  res_stall,
  output dcm_pkg::res_word_t                    res_word
);

  localparam int SB     = dcm_pkg::SAMPLE_BITS;
  localparam int MB     = dcm_pkg::MEAN_BITS;
  localparam int FB     = dcm_pkg::FRAC_BITS;
  localparam int CNT_W  = MAX_COUNT_BITS + 1;
  localparam int SUM_W  = SB + MAX_COUNT_BITS;
  localparam int NUM_W  = dcm_pkg::CFG_BITS + CNT_W + 1;
  localparam int DW     = SUM_W + FB;
  localparam int REM_W  = CNT_W + 1;
  localparam int STEP_W = $clog2(DW);
  localparam int P_CNT  = 1;
  localparam int P_MAG  = P_CNT + CNT_W;
  localparam int P_SUM  = P_MAG + SUM_W;
  localparam int P_SMP  = P_SUM + SUM_W;
  localparam int P_KIND = P_SMP + SB;

  typedef enum logic [1:0] {B_IDLE, B_MUL, B_DIV, B_OUT} state_t;
  typedef enum logic [1:0] {OP_MEAN, OP_ABS, OP_CORR} op_t;

  state_t                  st;
  op_t                     op;
  logic [STEP_W-1:0]       step;
  logic signed [SUM_W-1:0] w_sum;
  logic        [SUM_W-1:0] w_mag;
  logic        [CNT_W-1:0] w_cnt;
  logic                    w_sat;
  logic signed [NUM_W-1:0] prod;
  logic        [REM_W-1:0] d_rem;
  logic        [DW-1:0]    d_q;
  logic                    d_neg;
  logic        [MB-1:0]    res_ms;
  logic        [MB-1:0]    res_ma;
  logic        [SB-1:0]    res_corr;
  logic        [SB-1:0]    latched_correction;

  logic                    job_correct;
  logic signed [SB-1:0]    job_sample;
  logic                    out_free;
  logic                    res_load;
  op_t                     op_after;
  op_t                     load_op;
  logic                    sum_neg;
  logic        [SUM_W-1:0] sum_mag;
  logic signed [NUM_W-1:0] num;
  logic                    num_neg;
  logic        [NUM_W-1:0] num_mag;
  logic        [DW-1:0]    load_n;
  logic                    load_neg;
  logic        [REM_W-1:0] trial;
  logic                    ge;
  logic        [REM_W-1:0] rem_next;
  logic        [DW-1:0]    q_next;
  logic        [DW-1:0]    q_fin;
  logic                    cnt_zero;
  logic        [SB-1:0]    corr_val;

  assign job_correct = (q_data[P_KIND] == dcm_pkg::REQ_CORRECT);
  assign job_sample  = q_data[P_SMP +: SB];
  assign out_free    = !res_valid || !res_stall;
  assign q_pop       = (st == B_IDLE) && q_not_empty && (!job_correct || out_free);
  assign cnt_zero    = (w_cnt == '0);
  assign res_load    = (q_pop && job_correct) || ((st == B_OUT) && out_free);

  // Pick the next division
  always_comb begin
    unique case (op)
      OP_MEAN: op_after = OP_ABS;
      OP_ABS:  op_after = OP_CORR;
      default: op_after = OP_MEAN;
    endcase
    load_op = (st == B_MUL) ? op : op_after;
  end

  // Form the dividend magnitude and sign for the division being loaded
  always_comb begin
    sum_neg = w_sum[SUM_W-1];
    sum_mag = sum_neg ? SUM_W'(-w_sum) : SUM_W'(w_sum);
    num     = prod - NUM_W'(w_sum);
    num_neg = num[NUM_W-1];
    num_mag = num_neg ? NUM_W'(-num) : NUM_W'(num);
    unique case (load_op)
      OP_MEAN: begin
        load_n   = {sum_mag, FB'(0)};
        load_neg = sum_neg;
      end
      OP_ABS: begin
        load_n   = {w_mag, FB'(0)};
        load_neg = 1'b0;
      end
      default: begin
        load_n   = DW'(num_mag);
        load_neg = num_neg;
      end
    endcase
  end

  // One restoring division step: shift in a dividend bit, subtract if it fits
  always_comb begin
    trial    = {d_rem[REM_W-2:0], d_q[DW-1]};
    ge       = (trial >= {1'b0, w_cnt});
    rem_next = ge ? (trial - {1'b0, w_cnt}) : trial;
    q_next   = {d_q[DW-2:0], ge};
    q_fin    = d_neg ? DW'(-q_next) : q_next;
  end

  // Correction to latch at the end of a pass
  always_comb begin
    if (!apply_offset) begin
      corr_val = '0;
    end else if (cnt_zero) begin
      corr_val = SB'(target_offset);
    end else begin
      corr_val = res_corr;
    end
  end

  // Sequence jobs, run the shared divider and hold the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      st                 <= B_IDLE;
      op                 <= OP_MEAN;
      step               <= '0;
      res_valid          <= 1'b0;
      latched_correction <= '0;
    end else begin
      // Raise valid on a new result word, drop it once the old one is taken
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      unique case (st)
        B_IDLE: begin
          if (q_pop) begin
            if (job_correct) begin
              res_word.result_kind      <= dcm_pkg::RES_SAMPLE;
              res_word.mean_signed      <= '0;
              res_word.mean_abs         <= '0;
              res_word.correction       <= latched_correction;
              res_word.corrected_sample <= job_sample + latched_correction;
              res_word.count_saturated  <= 1'b0;
            end else begin
              w_sum <= q_data[P_SUM +: SUM_W];
              w_mag <= q_data[P_MAG +: SUM_W];
              w_cnt <= q_data[P_CNT +: CNT_W];
              w_sat <= q_data[0];
              op    <= OP_MEAN;
              st    <= B_MUL;
            end
          end
        end
        B_MUL: begin
          prod  <= NUM_W'(target_offset) * NUM_W'($signed({1'b0, w_cnt}));
          d_q   <= load_n;
          d_neg <= load_neg;
          d_rem <= '0;
          step  <= '0;
          st    <= B_DIV;
        end
        B_DIV: begin
          if (step == STEP_W'(DW - 1)) begin
            unique case (op)
              OP_MEAN: res_ms   <= q_fin[MB-1:0];
              OP_ABS:  res_ma   <= q_fin[MB-1:0];
              default: res_corr <= q_fin[SB-1:0];
            endcase
            if (op == OP_CORR) begin
              st <= B_OUT;
            end else begin
              op    <= op_after;
              d_q   <= load_n;
              d_neg <= load_neg;
              d_rem <= '0;
              step  <= '0;
            end
          end else begin
            d_rem <= rem_next;
            d_q   <= q_next;
            step  <= step + 1'b1;
          end
        end
        B_OUT: begin
          if (out_free) begin
            res_word.result_kind      <= dcm_pkg::RES_STATS;
            res_word.mean_signed      <= cnt_zero ? '0 : res_ms;
            res_word.mean_abs         <= cnt_zero ? '0 : res_ma;
            res_word.correction       <= corr_val;
            res_word.corrected_sample <= '0;
            res_word.count_saturated  <= w_sat;
            latched_correction        <= corr_val;
            st                        <= B_IDLE;
          end
        end
        default: st <= B_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/dc_mean_and_offset_corrector.sv =====
// Top level of the DC mean and offset corrector: configuration registers,
// front part, job queue and back part. Depends on dcm_pkg and the three submodules.
//
//  channel  | valid      | stall      | word      | direction
//  ---------+------------+------------+-----------+----------
//  request  | req_valid  | req_stall  | req_word  | in
//  result   | res_valid  | res_stall  | res_word  | out
//  config   | cfg_wr_en  | -          | cfg_wdata | in (cfg_index picks the register)
//
// A measure word without last gives no result.
// A correct word's result passes the job queue and the result register, one word per cycle
// while res_stall is low and the back part is idle. A last measure word is worked in the back
// part by the shared one-bit-per-cycle divider, run for both means and the correction.
// rst is synchronous and clears the accumulators, latched correction and registers.
// req_stall is high while the two-entry job queue is full.
`timescale 1ns / 1ps
`default_nettype none

module dc_mean_and_offset_corrector #(
  parameter int MAX_COUNT_BITS = dcm_pkg::MAX_COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  dcm_pkg::req_word_t             req_word,
  output logic                           res_valid,
  input  logic                           res_stall,
  output dcm_pkg::res_word_t             res_word,
  input  logic                           cfg_wr_en,
  input  logic                           cfg_index,
  input  logic [dcm_pkg::CFG_BITS-1:0]   cfg_wdata
);

  localparam int JOB_W = dcm_pkg::job_bits(MAX_COUNT_BITS);

  logic                                apply_offset;
  logic signed [dcm_pkg::CFG_BITS-1:0] target_offset;

  logic             q_full;
  logic             q_push;
  logic [JOB_W-1:0] q_push_data;
  logic             q_pop;
  logic [JOB_W-1:0] q_pop_data;
  logic             q_not_empty;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      apply_offset  <= 1'b0;
      target_offset <= '0;
    end else if (cfg_wr_en) begin
      if (cfg_index == dcm_pkg::CFG_APPLY_OFFSET) begin
        apply_offset <= cfg_wdata[0];
      end else begin
        target_offset <= cfg_wdata;
      end
    end
  end

  dcm_front #(
    .MAX_COUNT_BITS(MAX_COUNT_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_word (req_word),
    .req_stall(req_stall),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_push_data)
  );

  dcm_queue #(
    .W(JOB_W)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_push_data),
    .full     (q_full),
    .pop      (q_pop),
    .pop_data (q_pop_data),
    .not_empty(q_not_empty)
  );

  dcm_back #(
    .MAX_COUNT_BITS(MAX_COUNT_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .apply_offset (apply_offset),
    .target_offset(target_offset),
    .q_not_empty  (q_not_empty),
    .q_data       (q_pop_data),
    .q_pop        (q_pop),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .res_word     (res_word)
  );

endmodule

`default_nettype wire

// ===== design/dcm_checker.sv =====
// Port-level checker for the DC mean and offset corrector, bound to the top level.
// Depends on dcm_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module dcm_checker (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_stall,
  input dcm_pkg::req_word_t req_word,
  input logic               res_valid,
  input logic               res_stall,
  input dcm_pkg::res_word_t res_word
);

  logic [3:0]                       owed;
  logic [dcm_pkg::SAMPLE_BITS-1:0]  last_corr;
  logic                             req_take;
  logic                             res_take;
  logic                             earns;

  assign req_take = req_valid && !req_stall;
  assign res_take = res_valid && !res_stall;
  assign earns    = req_take && (req_word.req_type == dcm_pkg::REQ_CORRECT || req_word.last);

  // Track results owed and the correction of the latest statistics word
  always_ff @(posedge clk) begin
    if (rst) begin
      owed      <= '0;
      last_corr <= '0;
    end else begin
      if (earns && !res_take) begin
        owed <= owed + 1'b1;
      end else if (res_take && !earns) begin
        owed <= owed - 1'b1;
      end
      if (res_take && res_word.result_kind == dcm_pkg::RES_STATS) begin
        last_corr <= res_word.correction;
      end
    end
  end

  `DCM_ASSERT(res_holds, res_valid && res_stall |=> res_valid && $stable(res_word), "result word changed while stalled")
  `DCM_ASSERT_ALWAYS(res_idle_after_reset, rst |=> !res_valid, "result valid right after reset")
  `DCM_ASSERT(res_earned, res_valid |-> owed != 4'd0, "result without an earning request")
  `DCM_ASSERT(corr_matches, res_valid && res_word.result_kind == dcm_pkg::RES_SAMPLE |-> res_word.correction == last_corr, "corrected word uses a stale correction")

endmodule

bind dc_mean_and_offset_corrector dcm_checker u_checker (.*);

`default_nettype wire

// ===== test/tb_dc_mean_and_offset_corrector.sv =====
// Self-checking testbench for dc_mean_and_offset_corrector: directed and random
// measure and correct passes under several offset settings and idling patterns.
// Depends on dcm_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_dc_mean_and_offset_corrector;
  import dcm_pkg::*;

  localparam int LAST_CYCLES     = 3 * (MAX_COUNT_BITS_DEF + 32) + 3;
  localparam int SETTLE_CYCLES   = LAST_CYCLES + 20;
  localparam int WORDS_PER_PHASE = 216;
  localparam int PHASES          = 6;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                req_valid = 1'b0;
  logic                req_stall;
  req_word_t           req_word  = '0;
  logic                res_valid;
  logic                res_stall = 1'b0;
  res_word_t           res_word;
  logic                cfg_wr_en = 1'b0;
  logic                cfg_index = CFG_APPLY_OFFSET;
  logic [CFG_BITS-1:0] cfg_wdata = '0;

  // Stimulus and expectation stores
  req_word_t queued_words[$];
  res_word_t due_results[$];
  int        fails          = 0;
  int        send_idle_pct  = 0;
  int        recv_stall_pct = 0;

  // Predictor state, mirrors the block's accumulators and registers
  longint                   acc_sum    = 0;
  longint                   acc_mag    = 0;
  longint                   acc_count  = 0;
  logic signed [15:0]       held_corr  = '0;
  logic                     sat_seen   = 1'b0;
  logic                     cfg_apply  = 1'b0;
  logic        [15:0]       cfg_target = '0;

  dc_mean_and_offset_corrector uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_word  (req_word),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_word  (res_word),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advance the mean and offset model by one accepted word; queue any result it gives
  function void predict_dc_result(input req_word_t w);
    res_word_t r;
    longint    s;
    longint    corr;
    longint    ms;
    longint    ma;
    r = '0;
    s = $signed(w.sample);
    if (w.req_type == REQ_CORRECT) begin
      r.result_kind      = RES_SAMPLE;
      r.correction       = held_corr;
      r.corrected_sample = w.sample + held_corr;
      due_results.push_back(r);
      return;
    end
    // Hold the sums once the counter is full
    if (acc_count >= (longint'(1) << MAX_COUNT_BITS_DEF)) begin
      sat_seen = 1'b1;
    end else begin
      acc_sum   += s;
      acc_mag   += (s < 0) ? -s : s;
      acc_count += 1;
    end
    if (!w.last) return;
    ms   = 0;
    ma   = 0;
    corr = 0;
    if (acc_count != 0) begin
      ms = (acc_sum * 65536) / acc_count;
      ma = (acc_mag * 65536) / acc_count;
    end
    if (cfg_apply) begin
      if (acc_count == 0) corr = $signed(cfg_target);
      else corr = ($signed(cfg_target) * acc_count - acc_sum) / acc_count;
    end
    held_corr         = corr[15:0];
    r.result_kind     = RES_STATS;
    r.mean_signed     = ms[31:0];
    r.mean_abs        = ma[31:0];
    r.correction      = held_corr;
    r.count_saturated = sat_seen;
    due_results.push_back(r);
    acc_sum   = 0;
    acc_mag   = 0;
    acc_count = 0;
    sat_seen  = 1'b0;
  endfunction

  function void cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      fails++;
    end
  endfunction

  function void queue_word(input logic kind, input logic [15:0] smp, input logic lst);
    req_word_t w;
    w.req_type = kind;
    w.sample   = smp;
    w.last     = lst;
    queued_words.push_back(w);
  endfunction

  function logic [15:0] pick_sample(input int style, input int dc);
    int v;
    case (style)
      0: v = $urandom;
      1: begin
        case ($urandom_range(4))
          0: v = -32768;
          1: v = 32767;
          2: v = 0;
          3: v = -1;
          default: v = 1;
        endcase
      end
      default: v = dc + $urandom_range(64) - 32;
    endcase
    return v[15:0];
  endfunction

  // Driver: present queued words, idle at random
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) predict_dc_result(req_word);
      if (!req_valid || !req_stall) begin
        if (queued_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req_word  <= queued_words.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result word against the oldest one due
  always @(posedge clk) begin : result_check
    res_word_t want;
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        if (due_results.size() == 0) begin
          $error("result word with none due: %h", res_word);
          fails++;
        end else begin
          want = due_results.pop_front();
          cmp_field("result_kind", want.result_kind, res_word.result_kind);
          cmp_field("mean_signed", want.mean_signed, res_word.mean_signed);
          cmp_field("mean_abs", want.mean_abs, res_word.mean_abs);
          cmp_field("correction", want.correction, res_word.correction);
          cmp_field("corrected_sample", want.corrected_sample, res_word.corrected_sample);
          cmp_field("count_saturated", want.count_saturated, res_word.count_saturated);
        end
      end
      res_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Write both offset registers; only called while the block is idle
  task automatic set_offset_regs(input logic apply, input logic [15:0] target);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_APPLY_OFFSET;
    cfg_wdata <= {{(CFG_BITS-1){1'b0}}, apply};
    @(posedge clk);
    cfg_index <= CFG_TARGET_OFFSET;
    cfg_wdata <= target;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    cfg_apply  = apply;
    cfg_target = target;
  endtask

  // Wait for every word sent and every result back, then let the divider finish
  task automatic wait_drained();
    do @(negedge clk);
    while (queued_words.size() != 0 || req_valid || due_results.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic add_directed();
    // correct before any measure: correction still zero, last ignored
    queue_word(REQ_CORRECT, 16'h7FFF, 1'b1);
    queue_word(REQ_CORRECT, 16'h8000, 1'b0);
    // single most negative sample: extreme means, wrapped correction
    queue_word(REQ_MEASURE, 16'h8000, 1'b1);
    queue_word(REQ_CORRECT, 16'h7FFF, 1'b0);
    queue_word(REQ_CORRECT, 16'h8000, 1'b0);
    queue_word(REQ_CORRECT, 16'h0000, 1'b0);
    queue_word(REQ_MEASURE, 16'h7FFF, 1'b1);
    // fractional means, truncated toward zero both ways
    queue_word(REQ_MEASURE, 16'd3, 1'b0);
    queue_word(REQ_MEASURE, -16'sd2, 1'b0);
    queue_word(REQ_MEASURE, 16'd0, 1'b1);
    queue_word(REQ_MEASURE, 16'hFFFF, 1'b0);
    queue_word(REQ_MEASURE, 16'd0, 1'b0);
    queue_word(REQ_MEASURE, 16'd0, 1'b1);
    queue_word(REQ_CORRECT, 16'd1, 1'b0);
    // mixed extremes
    queue_word(REQ_MEASURE, 16'h8000, 1'b0);
    queue_word(REQ_MEASURE, 16'h7FFF, 1'b0);
    queue_word(REQ_MEASURE, 16'h8000, 1'b0);
    queue_word(REQ_MEASURE, 16'h8000, 1'b1);
    queue_word(REQ_CORRECT, 16'hFFFF, 1'b0);
    queue_word(REQ_CORRECT, 16'h7FFF, 1'b1);
  endtask

  // Mostly whole measure passes followed by correct runs, with some noise
  task automatic add_random(input int n);
    int added;
    int sel;
    int len;
    int style;
    int dc;
    added = 0;
    while (added < n) begin
      sel = $urandom_range(99);
      if (sel < 70) begin
        len   = ($urandom_range(9) == 0) ? $urandom_range(13, 80) : $urandom_range(1, 12);
        style = $urandom_range(2);
        dc    = int'($urandom_range(65535)) - 32768;
        for (int i = 0; i < len; i++)
          queue_word(REQ_MEASURE, pick_sample(style, dc), i == len - 1);
        added += len;
        len = $urandom_range(1, 12);
        for (int i = 0; i < len; i++)
          queue_word(REQ_CORRECT, pick_sample($urandom_range(2), dc), 1'($urandom_range(1)));
        added += len;
      end else if (sel < 85) begin
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++)
          queue_word(REQ_CORRECT, pick_sample($urandom_range(1), 0), 1'($urandom_range(1)));
        added += len;
      end else begin
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++)
          queue_word(1'($urandom_range(1)), 16'($urandom), 1'($urandom_range(1)));
        added += len;
      end
    end
  endtask

  initial begin : stimulus
    logic        apply;
    logic [15:0] target;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin apply = 1'b1; target = 16'h7FFF; end
        1: begin apply = 1'b1; target = 16'h8000; end
        2: begin apply = 1'b0; target = 16'($urandom); end
        3: begin apply = 1'b1; target = 16'h0000; end
        4: begin apply = 1'b1; target = 16'($urandom); end
        default: begin apply = 1'b0; target = 16'hFFFF; end
      endcase
      set_offset_regs(apply, target);
      // idling: sender light and receiver heavy, then swapped, then none
      if (p < 2) begin
        send_idle_pct  = 30;
        recv_stall_pct = 61;
      end else if (p < 4) begin
        send_idle_pct  = 61;
        recv_stall_pct = 30;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      if (p == 0) add_directed();
      add_random(WORDS_PER_PHASE);
      wait_drained();
    end
    if (due_results.size() != 0) begin
      $error("%0d result words never arrived", due_results.size());
      fails++;
    end
    if (fails == 0) begin
      $display("** dc_mean_and_offset_corrector: PASSED **");
    end else begin
      $display("** dc_mean_and_offset_corrector: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("** dc_mean_and_offset_corrector: FAILED **");
    $finish;
  end

endmodule
